@@ design/tlc_pkg.sv @@
// Package for the two-level cache tag controller.
// Holds status codes, config register indexes and shared types; no dependencies.
package tlc_pkg;

  localparam int unsigned AddrW = 32;
  localparam int unsigned CfgW  = 4;
  // widest index field: a 4-bit index width selects at most 15 bits
  localparam int unsigned IdxW  = 15;

  typedef enum logic [2:0] {
    ST_NONE       = 3'd0,
    ST_READ_HIT   = 3'd1,
    ST_READ_MISS  = 3'd2,
    ST_WRITE_HIT  = 3'd3,
    ST_WRITE_MISS = 3'd4
  } status_e;

  localparam logic [2:0] CFG_L1_OFF  = 3'd0;
  localparam logic [2:0] CFG_L1_IDX  = 3'd1;
  localparam logic [2:0] CFG_L1_WAYS = 3'd2;
  localparam logic [2:0] CFG_L2_OFF  = 3'd3;
  localparam logic [2:0] CFG_L2_IDX  = 3'd4;
  localparam logic [2:0] CFG_L2_WAYS = 3'd5;

  // one classified access as it travels from front to back
  typedef struct packed {
    logic              wr;
    logic [AddrW-1:0]  addr;
  } req_t;

  // extract the index field from an address
  function automatic logic [IdxW-1:0] set_field(input logic [AddrW-1:0] a,
                                                 input logic [3:0] ob,
                                                 input logic [3:0] ib);
    logic [AddrW-1:0] m;
    logic [AddrW-1:0] v;
    m = (AddrW'(1) << ib) - AddrW'(1);
    v = (a >> ob) & m;
    return v[IdxW-1:0];
  endfunction

  // extract the tag field; zero when offset plus index covers the word
  function automatic logic [AddrW-1:0] tag_field(input logic [AddrW-1:0] a,
                                                  input logic [3:0] ob,
                                                  input logic [3:0] ib);
    logic [5:0] sh;
    sh = 6'(ob) + 6'(ib);
    return (sh >= 6'd32) ? '0 : (a >> sh);
  endfunction

endpackage

@@ design/tlc_front.sv @@
// Front end: takes commands and feeds a two-entry queue.
// Depends on tlc_pkg.
module tlc_front import tlc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        opcode_i,
  input  logic [31:0] address_i,
  input  logic        pop_i,
  output logic        q_valid_o,
  output req_t        q_req_o
);

  logic [1:0] cnt_q, cnt_d;
  req_t       ent_q [2];
  logic       rd_q;
  logic       push;

  assign busy      = (cnt_q == 2'd2);
  assign push      = start && !busy;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_req_o   = ent_q[rd_q];

  always_comb begin
    cnt_d = cnt_q + 2'(push) - 2'(pop_i);
  end

  // advance the queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (pop_i) rd_q <= ~rd_q;
    end
  end

  // write the new word behind the current one
  always_ff @(posedge clk_i) begin
    if (push) ent_q[rd_q ^ cnt_q[0]] <= '{wr: opcode_i, addr: address_i};
  end

endmodule

@@ design/tlc_level.sv @@
// One cache level: tag/valid/rank rows in a one-row-per-set memory, lookup,
// touch and install. Depends on tlc_pkg. A row is read, then written back.
module tlc_level import tlc_pkg::*; #(
  parameter int unsigned SETS = 256,
  parameter int unsigned WAYS = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [3:0]       ways_cfg_i,
  input  logic             rd_i,
  input  logic [IdxW-1:0]  set_i,
  input  logic [AddrW-1:0] tag_i,
  output logic             ready_o,
  output logic             hit_o,
  input  logic             touch_i,
  input  logic             install_i,
  input  logic             force0_i
);

  localparam int unsigned SW = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned WW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam bit          Pow2 = ((SETS & (SETS - 1)) == 0);
  localparam int unsigned FoldSh = IdxW + SW;
  localparam longint unsigned FoldMul = ((64'd1 << FoldSh) + SETS - 1) / SETS;

  typedef struct packed {
    logic [WAYS-1:0][AddrW-1:0] tag;
    logic [WAYS-1:0]            vld;
    logic [WAYS-1:0][WW-1:0]    rnk;
  } row_t;

  row_t          row_mem [SETS];
  row_t          row_q, row_d;
  logic [SW-1:0] s_fold, s_q, clr_q;
  logic          clr_busy_q;
  logic [31:0]   quo, rem;
  logic [4:0]    n;
  logic [WW-1:0] hitw, pick, tw, r;
  logic          inv_found, upd;

  // fold the index field into the sets that exist
  always_comb begin
    quo = (32'(set_i) * 32'(FoldMul)) >> FoldSh;
    rem = 32'(set_i) - quo * 32'(SETS);
    if (SETS == 1) s_fold = '0;
    else if (Pow2) s_fold = set_i[SW-1:0];
    else s_fold = rem[SW-1:0];
  end

  // clamp ways in use
  always_comb begin
    if (ways_cfg_i == 4'd0) n = 5'd1;
    else if (5'(ways_cfg_i) > 5'(WAYS)) n = 5'(WAYS);
    else n = 5'(ways_cfg_i);
  end

  // step through every row once after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= '0;
      clr_busy_q <= 1'b1;
    end else if (clr_busy_q) begin
      clr_q <= clr_q + SW'(1);
      if (clr_q == SW'(SETS - 1)) clr_busy_q <= 1'b0;
    end
  end

  assign ready_o = !clr_busy_q;

  // hold the set of the row being worked on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q <= '0;
    end else if (rd_i) begin
      s_q <= s_fold;
    end
  end

  // clear, write back and read the row memory
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) row_mem[clr_q] <= '0;
    else if (upd) row_mem[s_q] <= row_d;
    if (rd_i) row_q <= row_mem[s_fold];
  end

  // lookup, victim choice and touch target on the row read
  always_comb begin
    hit_o = 1'b0; hitw = '0; inv_found = 1'b0; pick = '0;
    for (int w = WAYS-1; w >= 0; w--) begin
      if (5'(w) < n && row_q.vld[w] && row_q.tag[w] == tag_i) begin
        hit_o = 1'b1; hitw = WW'(w);
      end
      if (5'(w) < n && !row_q.vld[w]) begin
        inv_found = 1'b1; pick = WW'(w);
      end
    end
    if (!inv_found) begin
      pick = '0;
      for (int w = 1; w < WAYS; w++)
        if (5'(w) < n && row_q.rnk[w] < row_q.rnk[pick]) pick = WW'(w);
    end
    if (install_i) tw = pick;
    else if (force0_i) tw = '0;
    else tw = hitw;
    r = row_q.rnk[tw];
  end

  // build the row to write back
  always_comb begin
    upd   = touch_i || install_i || force0_i;
    row_d = row_q;
    if (install_i || (force0_i && !hit_o)) begin
      row_d.tag[tw] = tag_i;
      row_d.vld[tw] = 1'b1;
    end
    for (int w = 0; w < WAYS; w++)
      if (5'(w) < n && WW'(w) != tw && row_q.rnk[w] > r)
        row_d.rnk[w] = row_q.rnk[w] - 1'b1;
    row_d.rnk[tw] = WW'(n - 5'd1);
  end

endmodule

@@ design/tlc_back.sv @@
// Back end: pops one queued word, looks up both levels, updates them, reports.
// Depends on tlc_pkg and tlc_level.
module tlc_back import tlc_pkg::*; #(
  parameter int unsigned L1_SETS = 256,
  parameter int unsigned L1_WAYS = 4,
  parameter int unsigned L2_SETS = 1024,
  parameter int unsigned L2_WAYS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  req_t       q_req_i,
  output logic       pop_o,
  input  logic [3:0] l1_off_i, l1_idx_i, l2_off_i, l2_idx_i, l2_ways_i,
  input  logic [2:0] l1_ways_i,
  output logic       done_o,
  output logic [2:0] l1_status_o,
  output logic [2:0] l2_status_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_UPD  = 1'b1;

  logic state_q, state_d;
  logic h1, h2, t1, t2, i1, i2, f2, r1, r2, act;
  logic [IdxW-1:0]  s1, s2;
  logic [AddrW-1:0] g1, g2;
  req_t req_q;
  status_e st1, st2;

  assign act   = (state_q == S_UPD);
  assign pop_o = (state_q == S_IDLE) && q_valid_i && r1 && r2;
  assign s1 = set_field(q_req_i.addr, l1_off_i, l1_idx_i);
  assign s2 = set_field(q_req_i.addr, l2_off_i, l2_idx_i);
  assign g1 = tag_field(req_q.addr, l1_off_i, l1_idx_i);
  assign g2 = tag_field(req_q.addr, l2_off_i, l2_idx_i);

  // read rows on a pop, update them on the next cycle
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (pop_o) state_d = S_UPD;
      S_UPD:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // decide the actions for each level
  always_comb begin
    t1 = 1'b0; i1 = 1'b0; t2 = 1'b0; i2 = 1'b0; f2 = 1'b0;
    if (!req_q.wr) begin
      if (h1) begin
        st1 = ST_READ_HIT; st2 = ST_NONE; t1 = 1'b1;
      end else begin
        st1 = ST_READ_MISS; i1 = 1'b1;
        if (h2) begin st2 = ST_READ_HIT; t2 = 1'b1; end
        else begin st2 = ST_READ_MISS; i2 = 1'b1; end
      end
    end else if (h1) begin
      st1 = ST_WRITE_HIT; st2 = ST_WRITE_HIT; t1 = 1'b1; t2 = 1'b1;
      f2 = !h2;
    end else begin
      st1 = ST_WRITE_MISS;
      if (h2) begin st2 = ST_WRITE_HIT; t2 = 1'b1; end
      else st2 = ST_WRITE_MISS;
    end
    t1 = t1 & act; i1 = i1 & act;
    t2 = t2 & act; i2 = i2 & act; f2 = f2 & act;
  end

  tlc_level #(.SETS(L1_SETS), .WAYS(L1_WAYS)) u_l1 (
    .clk_i, .rst_ni, .ways_cfg_i({1'b0, l1_ways_i}), .rd_i(pop_o), .set_i(s1),
    .tag_i(g1), .ready_o(r1), .hit_o(h1), .touch_i(t1), .install_i(i1),
    .force0_i(1'b0));

  tlc_level #(.SETS(L2_SETS), .WAYS(L2_WAYS)) u_l2 (
    .clk_i, .rst_ni, .ways_cfg_i(l2_ways_i), .rd_i(pop_o), .set_i(s2),
    .tag_i(g2), .ready_o(r2), .hit_o(h2), .touch_i(t2), .install_i(i2),
    .force0_i(f2));

  // advance the state and register the result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_o  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_o  <= act;
    end
  end

  // hold the popped word and register the result word
  always_ff @(posedge clk_i) begin
    if (pop_o) req_q <= q_req_i;
    if (act) begin
      l1_status_o <= st1;
      l2_status_o <= st2;
    end
  end

endmodule

@@ design/two_level_lru_cache_tag_controller_core.sv @@
// Two-level LRU cache tag controller: one read or write per start pulse, one
// status pair per access, strobed on done_o for a single cycle. Each level keeps
// its tags, valid bits and ranks in a memory with one row per set, so an access
// is served as a row read, then the compare and the row write-back. The back end
// pops a new word only while idle, so accesses do not overlap. A two-word queue
// sits in front, so busy rises only when two words wait. After reset each level
// clears its rows at one per cycle; words are queued but not served until both
// levels have cleared all their rows. The receiver cannot stall: every done_o
// pulse carries a result. Depends on tlc_pkg, tlc_front, tlc_back.
module two_level_lru_cache_tag_controller_core import tlc_pkg::*; #(
  parameter int unsigned L1_SETS = 256,
  parameter int unsigned L1_WAYS = 4,
  parameter int unsigned L2_SETS = 1024,
  parameter int unsigned L2_WAYS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        opcode_i,
  input  logic [31:0] address_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [3:0]  cfg_wdata_i,
  output logic        done_o,
  output logic [2:0]  l1_status_o,
  output logic [2:0]  l2_status_o
);

  logic [3:0] l1_off_q, l1_idx_q, l2_off_q, l2_idx_q, l2_ways_q;
  logic [2:0] l1_ways_q;
  logic       qv, pop;
  req_t       qr;

  // hold config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l1_off_q <= 4'd5; l1_idx_q <= 4'd8; l1_ways_q <= 3'd4;
      l2_off_q <= 4'd6; l2_idx_q <= 4'd10; l2_ways_q <= 4'd8;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_L1_OFF:  l1_off_q  <= cfg_wdata_i;
        CFG_L1_IDX:  l1_idx_q  <= cfg_wdata_i;
        CFG_L1_WAYS: l1_ways_q <= cfg_wdata_i[2:0];
        CFG_L2_OFF:  l2_off_q  <= cfg_wdata_i;
        CFG_L2_IDX:  l2_idx_q  <= cfg_wdata_i;
        CFG_L2_WAYS: l2_ways_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  tlc_front u_front (
    .clk_i, .rst_ni, .start, .busy, .opcode_i, .address_i,
    .pop_i(pop), .q_valid_o(qv), .q_req_o(qr));

  tlc_back #(.L1_SETS(L1_SETS), .L1_WAYS(L1_WAYS),
             .L2_SETS(L2_SETS), .L2_WAYS(L2_WAYS)) u_back (
    .clk_i, .rst_ni, .q_valid_i(qv), .q_req_i(qr), .pop_o(pop),
    .l1_off_i(l1_off_q), .l1_idx_i(l1_idx_q), .l2_off_i(l2_off_q),
    .l2_idx_i(l2_idx_q), .l2_ways_i(l2_ways_q), .l1_ways_i(l1_ways_q),
    .done_o, .l1_status_o, .l2_status_o);

endmodule
